// File: hw/rtl/dltq_pkg.sv
// Shared types and constants for the delta-list timer queue.
package dltq_pkg;
  localparam int NUM_SLOTS  = 16;
  localparam int DELAY_BITS = 16;
  localparam int SLOT_W     = 4;
  localparam int CNT_W      = $clog2(NUM_SLOTS + 1);
  localparam int IDX_W      = $clog2(NUM_SLOTS);
  localparam int CMDQ_DEPTH = 2;
  localparam int RESQ_DEPTH = 4;

  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_ARM    = 2'd1,
    FUNC_CANCEL = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    KIND_ARM    = 2'd0,
    KIND_CANCEL = 2'd1,
    KIND_EXPIRE = 2'd2,
    KIND_IDLE   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ARM_SCAN, ST_CAN_SCAN, ST_SHIFT, ST_TICK, ST_EXP
  } state_e;

  typedef struct packed {
    func_e                 func;
    logic [SLOT_W-1:0]     slot;
    logic [DELAY_BITS-1:0] delay;
  } cmd_t;

  typedef struct packed {
    kind_e             kind;
    logic              status;
    logic [SLOT_W-1:0] slot;
    logic              last;
    logic              irq;
  } res_t;
endpackage

// File: hw/rtl/dltq_front.sv
// Front end: takes input transfers and queues valid commands for the engine.
module dltq_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            full_o,
  input  dltq_pkg::cmd_t  cmd_i,
  output logic            cmd_valid_o,
  input  logic            cmd_take_i,
  output dltq_pkg::cmd_t  cmd_o
);
  import dltq_pkg::*;
  localparam int PW = $clog2(CMDQ_DEPTH);
  cmd_t            mem_q [CMDQ_DEPTH];
  logic [PW-1:0]   wp_q, rp_q;
  logic [PW:0]     cnt_q;
  logic            wr, rd;

  assign full_o      = (cnt_q == (PW+1)'(CMDQ_DEPTH));
  // Unused function codes are dropped here; they produce no results.
  assign wr          = push_i && !full_o && (cmd_i.func != FUNC_NONE);
  assign cmd_valid_o = (cnt_q != '0);
  assign rd          = cmd_take_i && cmd_valid_o;
  assign cmd_o       = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + 1'b1;
      if (rd) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (PW+1)'(wr) - (PW+1)'(rd);
    end
  end
endmodule

// File: hw/rtl/dltq_engine.sv
// Back end: sorted delta-list engine that walks entries one per cycle.
module dltq_engine (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  output logic            cmd_take_o,
  input  dltq_pkg::cmd_t  cmd_i,
  output logic            res_valid_o,
  output dltq_pkg::res_t  res_o,
  input  logic            res_space_i
);
  import dltq_pkg::*;
  logic [SLOT_W-1:0]     oslot_q  [NUM_SLOTS];
  logic [DELAY_BITS-1:0] odelta_q [NUM_SLOTS];
  logic [CNT_W-1:0]      cnt_q;
  logic [NUM_SLOTS-1:0]  mask_q;
  state_e                st_q, st_d;
  cmd_t                  c_q;
  logic [CNT_W-1:0]      i_q, i_d;
  logic [DELAY_BITS-1:0] rem_q, rem_d;
  logic                  ins_q, ins_d; // shift direction: 1 insert, 0 remove
  logic                  any_q, any_d;
  logic [IDX_W-1:0]      ix;
  logic                  slot_ok;
  logic                  armed;

  assign ix      = i_q[IDX_W-1:0];
  assign slot_ok = ({1'b0, c_q.slot} < (SLOT_W+1)'(NUM_SLOTS));
  assign armed   = slot_ok && mask_q[c_q.slot[IDX_W-1:0]];
  assign cmd_take_o = (st_q == ST_IDLE) && cmd_valid_i;

  logic [CNT_W-1:0] cnt_m1;
  assign cnt_m1 = cnt_q - 1'b1;

  always_comb begin
    st_d = st_q; i_d = i_q; rem_d = rem_q; ins_d = ins_q; any_d = any_q;
    res_valid_o = 1'b0;
    res_o = '{kind: KIND_IDLE, status: 1'b0, slot: '0, last: 1'b1,
              irq: (cnt_q != '0)};
    unique case (st_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          i_d = '0;
          any_d = 1'b0;
          rem_d = (cmd_i.delay != '0) ? cmd_i.delay - 1'b1 : '0;
          unique case (cmd_i.func)
            FUNC_ARM:    st_d = ST_ARM_SCAN;
            FUNC_CANCEL: st_d = ST_CAN_SCAN;
            default:     st_d = ST_TICK;
          endcase
        end
      end
      ST_ARM_SCAN: begin
        if (!slot_ok || mask_q[c_q.slot[IDX_W-1:0]] ||
            cnt_q == CNT_W'(NUM_SLOTS)) begin
          if (res_space_i) begin
            res_valid_o = 1'b1;
            res_o.kind = KIND_ARM; res_o.status = 1'b1; res_o.slot = c_q.slot;
            st_d = ST_IDLE;
          end
        end else if (i_q < cnt_q && rem_q >= odelta_q[ix]) begin
          rem_d = rem_q - odelta_q[ix];
          i_d = i_q + 1'b1;
        end else begin
          ins_d = 1'b1;
          st_d = ST_SHIFT;
        end
      end
      ST_CAN_SCAN: begin
        if (!armed) begin
          if (res_space_i) begin
            res_valid_o = 1'b1;
            res_o.kind = KIND_CANCEL; res_o.status = 1'b1; res_o.slot = c_q.slot;
            st_d = ST_IDLE;
          end
        end else if (oslot_q[ix] != c_q.slot) begin
          i_d = i_q + 1'b1;
        end else begin
          ins_d = 1'b0;
          st_d = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (res_space_i) begin
          res_valid_o = 1'b1;
          res_o.kind = ins_q ? KIND_ARM : KIND_CANCEL;
          res_o.slot = c_q.slot;
          res_o.irq = ins_q ? 1'b1 : (cnt_m1 != '0);
          st_d = ST_IDLE;
        end
      end
      ST_TICK: st_d = ST_EXP;
      ST_EXP: begin
        if (res_space_i) begin
          if (cnt_q != '0 && odelta_q[0] == '0) begin
            res_valid_o = 1'b1;
            res_o.kind = KIND_EXPIRE; res_o.slot = oslot_q[0];
            res_o.irq = (cnt_m1 != '0);
            res_o.last = !(cnt_m1 != '0 && odelta_q[1] == '0);
            any_d = 1'b1;
            if (res_o.last) st_d = ST_IDLE;
          end else begin
            res_valid_o = !any_q;
            st_d = ST_IDLE;
          end
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // The whole list shifts together; each entry looks only at a neighbor or at the new entry.
  always_ff @(posedge clk_i) begin
    if (st_q == ST_IDLE && cmd_valid_i) c_q <= cmd_i;
    if (st_q == ST_SHIFT && res_space_i) begin
      for (int k = 0; k < NUM_SLOTS; k++) begin
        if (ins_q) begin
          if (CNT_W'(k) == i_q) begin
            oslot_q[k]  <= c_q.slot;
            odelta_q[k] <= rem_q;
          end else if (CNT_W'(k) == i_q + 1'b1 && i_q < cnt_q && k > 0) begin
            oslot_q[k]  <= oslot_q[k-1];
            odelta_q[k] <= odelta_q[k-1] - rem_q;
          end else if (CNT_W'(k) > i_q && CNT_W'(k) <= cnt_q && k > 0) begin
            oslot_q[k]  <= oslot_q[k-1];
            odelta_q[k] <= odelta_q[k-1];
          end
        end else begin
          if (CNT_W'(k) >= i_q && CNT_W'(k) + 1'b1 < cnt_q && k + 1 < NUM_SLOTS) begin
            oslot_q[k] <= oslot_q[k+1];
            if (CNT_W'(k) == i_q) begin
              logic [DELAY_BITS:0] s;
              s = {1'b0, odelta_q[k+1]} + {1'b0, odelta_q[k]};
              odelta_q[k] <= s[DELAY_BITS] ? '1 : s[DELAY_BITS-1:0];
            end else begin
              odelta_q[k] <= odelta_q[k+1];
            end
          end
        end
      end
    end
    if (st_q == ST_TICK && cnt_q != '0 && odelta_q[0] != '0)
      odelta_q[0] <= odelta_q[0] - 1'b1;
    if (st_q == ST_EXP && res_space_i && cnt_q != '0 && odelta_q[0] == '0) begin
      for (int k = 0; k + 1 < NUM_SLOTS; k++) begin
        oslot_q[k]  <= oslot_q[k+1];
        odelta_q[k] <= odelta_q[k+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; cnt_q <= '0; mask_q <= '0;
      i_q <= '0; rem_q <= '0; ins_q <= 1'b0; any_q <= 1'b0;
    end else begin
      st_q <= st_d; i_q <= i_d; rem_q <= rem_d; ins_q <= ins_d; any_q <= any_d;
      if (st_q == ST_SHIFT && res_space_i) begin
        if (ins_q) begin
          cnt_q <= cnt_q + 1'b1;
          mask_q[c_q.slot[IDX_W-1:0]] <= 1'b1;
        end else begin
          cnt_q <= cnt_m1;
          mask_q[c_q.slot[IDX_W-1:0]] <= 1'b0;
        end
      end
      if (st_q == ST_EXP && res_space_i && cnt_q != '0 && odelta_q[0] == '0) begin
        cnt_q <= cnt_m1;
        mask_q[oslot_q[0][IDX_W-1:0]] <= 1'b0;
      end
    end
  end
endmodule

// File: hw/rtl/dltq_resq.sv
// Result queue between the engine and the output port.
module dltq_resq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  dltq_pkg::res_t  res_i,
  output logic            space_o,
  output logic            empty_o,
  input  logic            pop_i,
  output dltq_pkg::res_t  res_o
);
  import dltq_pkg::*;
  localparam int PW = $clog2(RESQ_DEPTH);
  res_t          mem_q [RESQ_DEPTH];
  logic [PW-1:0] wp_q, rp_q;
  logic [PW:0]   cnt_q;
  logic          rd;

  assign space_o = (cnt_q != (PW+1)'(RESQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rd      = pop_i && !empty_o;
  assign res_o   = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= res_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr_i) wp_q <= wp_q + 1'b1;
      if (rd) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (PW+1)'(wr_i) - (PW+1)'(rd);
    end
  end
endmodule

// File: hw/rtl/delta_list_timer_queue.sv
// Top level of the delta-list timer queue.
// Usage: the input side is a queue. Drive func_i, slot_id_i and
// delay_frames_i with push; a transfer happens when push is high and
// full is low. A two-entry command queue decouples the front from the
// list engine, so a new command is taken while the engine is busy.
// The result side is also a queue. While empty is low the oldest result
// is shown on kind_o, status_o, expired_slot_o, last_o and
// frame_irq_enable_o; a transfer happens when pop is high and empty is low.
// Processing: an arm walks the sorted list one entry per cycle, passing
// at most 15 entries, and a cancel walks it until it finds the slot. A tick
// decrements the head delta, then gives one expire result per expired slot,
// or one idle result when none expires. A rejected arm or cancel is answered
// straight from its scan. The engine works on a single command at a time,
// and it waits to write a result while the result queue is full.
// When the receiver stalls, the four-entry result queue fills, the engine
// waits, and then the command queue fills and full rises.
// Reset (rst_ni low) empties both queues and disarms every slot.
module delta_list_timer_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  func_i,
  input  logic [3:0]  slot_id_i,
  input  logic [15:0] delay_frames_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind_o,
  output logic        status_o,
  output logic [3:0]  expired_slot_o,
  output logic        last_o,
  output logic        frame_irq_enable_o
);
  import dltq_pkg::*;
  cmd_t cmd_in, cmd;
  res_t res_w, res_out;
  logic cmd_valid, cmd_take, res_valid, res_space;

  assign cmd_in.func  = func_e'(func_i);
  assign cmd_in.slot  = slot_id_i;
  assign cmd_in.delay = delay_frames_i;

  dltq_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .cmd_i(cmd_in),
    .cmd_valid_o(cmd_valid), .cmd_take_i(cmd_take), .cmd_o(cmd)
  );

  dltq_engine u_engine (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_take_o(cmd_take),
    .cmd_i(cmd), .res_valid_o(res_valid), .res_o(res_w),
    .res_space_i(res_space)
  );

  dltq_resq u_resq (
    .clk_i, .rst_ni, .wr_i(res_valid), .res_i(res_w), .space_o(res_space),
    .empty_o(empty), .pop_i(pop), .res_o(res_out)
  );

  assign kind_o             = res_out.kind;
  assign status_o           = res_out.status;
  assign expired_slot_o     = res_out.slot;
  assign last_o             = res_out.last;
  assign frame_irq_enable_o = res_out.irq;
endmodule

// File: hw/rtl/dltq_checker.sv
// Port-level checker for the delta-list timer queue, bound to the top level.
module dltq_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [1:0] kind_o,
  input logic       status_o,
  input logic       last_o,
  input logic [3:0] expired_slot_o
);
  import dltq_pkg::*;
  a_ans_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && (kind_o == KIND_ARM || kind_o == KIND_CANCEL) |-> last_o)
    else $error("answer without last");
  a_idle_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && kind_o == KIND_IDLE |-> !status_o && last_o && expired_slot_o == '0)
    else $error("bad idle tick result");
  a_exp_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && kind_o == KIND_EXPIRE |-> !status_o)
    else $error("expire rejected");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(kind_o))
    else $error("result dropped");
endmodule

bind delta_list_timer_queue dltq_checker u_chk (
  .clk_i, .rst_ni, .empty, .pop, .kind_o, .status_o, .last_o, .expired_slot_o
);
